// File: design/tcpsar_pkg.sv
package tcpsar_pkg;

    localparam int SESSIONS = 32;
    localparam int IDX_W    = $clog2(SESSIONS);

    localparam logic [2:0] ACT_TX_RD   = 3'd0;
    localparam logic [2:0] ACT_TX_WR   = 3'd1;
    localparam logic [2:0] ACT_RTX_WR  = 3'd2;
    localparam logic [2:0] ACT_APP_PSH = 3'd3;
    localparam logic [2:0] ACT_RX_RD   = 3'd4;
    localparam logic [2:0] ACT_RX_WR   = 3'd5;

    localparam logic [1:0] KIND_TX_REPLY = 2'd0;
    localparam logic [1:0] KIND_RX_REPLY = 2'd1;
    localparam logic [1:0] KIND_ACK_PUSH = 2'd2;
    localparam logic [1:0] KIND_INIT_PSH = 2'd3;

    localparam logic [15:0] INIT_CWND = 16'h3908;
    localparam logic [15:0] INIT_SSTH = 16'hFFFF;

    localparam int FLAG_FRDY = 0;
    localparam int FLAG_FSNT = 1;
    localparam int FLAG_FRTX = 2;

    typedef struct packed {
        logic [31:0] acked;
        logic [31:0] unacked;
        logic [15:0] app;
        logic [15:0] peer_win;
        logic [15:0] cwnd;
        logic [15:0] ssth;
        logic [1:0]  dup;
        logic [2:0]  flags;
    } t_entry;

    typedef struct packed {
        logic [2:0]  action;
        logic [4:0]  session;
        logic [31:0] seq_value;
        logic        init;
        logic        fin_ready;
        logic        fin_sent;
        logic [15:0] threshold;
        logic [15:0] rx_peer_win;
        logic [15:0] rx_cwnd;
        logic [1:0]  dup_count;
        logic        fast_rexmit;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  session;
        logic [31:0] acked;
        logic [31:0] not_acked;
        logic [15:0] window;
        logic [15:0] app_ptr;
        logic        fin_ready;
        logic        fin_sent;
        logic [15:0] threshold;
        logic [1:0]  dup_count;
        logic        fast_rexmit;
    } t_result;

    typedef struct packed {
        logic wr;
        logic res_vld;
    } t_upd_ctl;

endpackage

// File: design/tcp_tx_sar_session_table_top.sv
// accept registers the request and table read; the result then loads the output register
// throughput: one request per cycle unless stalled; the table read in one cycle and the
// read-modify-write in the next overlap, with the write forwarded to a read of the same
// session; a stalled full output register holds a result-bearing request, then the input
// reset: synchronous, active low; clears control and the per-entry valid bits, so every
// session reads as all zero right after reset with no clearing pass
module tcp_tx_sar_session_table_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_action,
    input  logic [4:0]  i_session,
    input  logic [31:0] i_seq_value,
    input  logic        i_init,
    input  logic        i_fin_ready_in,
    input  logic        i_fin_sent_in,
    input  logic [15:0] i_threshold_in,
    input  logic [15:0] i_rx_peer_win_in,
    input  logic [15:0] i_rx_cwnd_in,
    input  logic [1:0]  i_dup_count_in,
    input  logic        i_fast_rexmit_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_result_kind,
    output logic [4:0]  o_session_out,
    output logic [31:0] o_acked_out,
    output logic [31:0] o_not_acked_out,
    output logic [15:0] o_window_out,
    output logic [15:0] o_app_ptr_out,
    output logic        o_fin_ready_out,
    output logic        o_fin_sent_out,
    output logic [15:0] o_threshold_out,
    output logic [1:0]  o_dup_count_out,
    output logic        o_fast_rexmit_out
);

    logic                 acc_in;
    logic                 exec_done;
    logic                 out_free;
    logic                 wr_en;
    logic                 r_busy;
    logic                 r_out_vld;
    tcpsar_pkg::t_item    n_item;
    tcpsar_pkg::t_item    r_item;
    tcpsar_pkg::t_entry   rd_entry;
    tcpsar_pkg::t_entry   nxt_entry;
    tcpsar_pkg::t_upd_ctl upd_ctl;
    tcpsar_pkg::t_result  res;
    tcpsar_pkg::t_result  r_out;

    assign n_item = '{
        action:      i_action,
        session:     i_session,
        seq_value:   i_seq_value,
        init:        i_init,
        fin_ready:   i_fin_ready_in,
        fin_sent:    i_fin_sent_in,
        threshold:   i_threshold_in,
        rx_peer_win: i_rx_peer_win_in,
        rx_cwnd:     i_rx_cwnd_in,
        dup_count:   i_dup_count_in,
        fast_rexmit: i_fast_rexmit_in
    };

    assign out_free  = !r_out_vld || !i_stall;
    assign exec_done = r_busy && (!upd_ctl.res_vld || out_free);
    assign o_stall   = r_busy && !exec_done;
    assign acc_in    = i_valid && !o_stall;
    assign wr_en     = exec_done && upd_ctl.wr;

    tcpsar_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (acc_in),
        .i_rd_idx  (i_session[tcpsar_pkg::IDX_W-1:0]),
        .i_wr_en   (wr_en),
        .i_wr_idx  (r_item.session[tcpsar_pkg::IDX_W-1:0]),
        .i_wr_data (nxt_entry),
        .o_rd_data (rd_entry)
    );

    tcpsar_upd u_upd (
        .i_item (r_item),
        .i_cur  (rd_entry),
        .o_nxt  (nxt_entry),
        .o_ctl  (upd_ctl),
        .o_res  (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (acc_in) begin
                r_busy <= 1'b1;
            end else if (exec_done) begin
                r_busy <= 1'b0;
            end
            if (exec_done && upd_ctl.res_vld) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_item <= n_item;
        end
        if (exec_done && upd_ctl.res_vld) begin
            r_out <= res;
        end
    end

    assign o_valid           = r_out_vld;
    assign o_result_kind     = r_out.kind;
    assign o_session_out     = r_out.session;
    assign o_acked_out       = r_out.acked;
    assign o_not_acked_out   = r_out.not_acked;
    assign o_window_out      = r_out.window;
    assign o_app_ptr_out     = r_out.app_ptr;
    assign o_fin_ready_out   = r_out.fin_ready;
    assign o_fin_sent_out    = r_out.fin_sent;
    assign o_threshold_out   = r_out.threshold;
    assign o_dup_count_out   = r_out.dup_count;
    assign o_fast_rexmit_out = r_out.fast_rexmit;

    a_no_out_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_stall) |-> !(exec_done && upd_ctl.res_vld))
        else $error("pending result overwritten");

    a_accept_fills_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_in |=> r_busy)
        else $error("accepted request not in execute stage");

    a_write_only_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> r_busy)
        else $error("table write without a request in execute");

    a_push_session: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_done && upd_ctl.res_vld && (res.kind == tcpsar_pkg::KIND_ACK_PUSH ||
         res.kind == tcpsar_pkg::KIND_INIT_PSH)) |=> (o_session_out == $past(r_item.session)))
        else $error("push carries wrong session");

endmodule

// File: design/tcpsar_mem.sv
module tcpsar_mem (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [tcpsar_pkg::IDX_W-1:0]  i_rd_idx,
    input  logic                          i_wr_en,
    input  logic [tcpsar_pkg::IDX_W-1:0]  i_wr_idx,
    input  tcpsar_pkg::t_entry            i_wr_data,
    output tcpsar_pkg::t_entry            o_rd_data
);

    tcpsar_pkg::t_entry r_mem [tcpsar_pkg::SESSIONS];
    logic [tcpsar_pkg::SESSIONS-1:0] r_vld;
    tcpsar_pkg::t_entry r_rd_q;
    logic               r_rd_vld;
    logic               r_fwd;
    tcpsar_pkg::t_entry r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_q <= r_mem[i_rd_idx];
        end
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_fwd    <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_idx];
                r_fwd    <= i_wr_en && (i_wr_idx == i_rd_idx);
            end
        end
    end

    // write in the same cycle as a read of that entry bypasses the array
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_data <= i_wr_data;
        end
    end

    always_comb begin
        if (r_fwd) begin
            o_rd_data = r_fwd_data;
        end else if (r_rd_vld) begin
            o_rd_data = r_rd_q;
        end else begin
            o_rd_data = '0;
        end
    end

endmodule

// File: design/tcpsar_upd.sv
module tcpsar_upd (
    input  tcpsar_pkg::t_item    i_item,
    input  tcpsar_pkg::t_entry   i_cur,
    output tcpsar_pkg::t_entry   o_nxt,
    output tcpsar_pkg::t_upd_ctl o_ctl,
    output tcpsar_pkg::t_result  o_res
);

    logic               ok;
    tcpsar_pkg::t_entry cur;

    assign ok  = 32'(i_item.session) < tcpsar_pkg::SESSIONS;
    assign cur = ok ? i_cur : '0;

    always_comb begin
        o_nxt = cur;
        o_ctl = '0;
        o_res = '0;
        unique case (i_item.action)
            tcpsar_pkg::ACT_TX_RD: begin
                o_ctl.res_vld   = 1'b1;
                o_res.kind      = tcpsar_pkg::KIND_TX_REPLY;
                o_res.acked     = cur.acked;
                o_res.not_acked = cur.unacked;
                o_res.window    = (cur.cwnd < cur.peer_win) ? cur.cwnd : cur.peer_win;
                o_res.app_ptr   = cur.app;
                o_res.fin_ready = cur.flags[tcpsar_pkg::FLAG_FRDY];
                o_res.fin_sent  = cur.flags[tcpsar_pkg::FLAG_FSNT];
            end
            tcpsar_pkg::ACT_TX_WR: begin
                o_ctl.wr      = ok;
                o_nxt.unacked = i_item.seq_value;
                if (i_item.init) begin
                    o_nxt.app   = i_item.seq_value[15:0];
                    o_nxt.acked = i_item.seq_value - 32'd1;
                    o_nxt.cwnd  = tcpsar_pkg::INIT_CWND;
                    o_nxt.ssth  = tcpsar_pkg::INIT_SSTH;
                    o_nxt.flags[tcpsar_pkg::FLAG_FRDY] = i_item.fin_ready;
                    o_nxt.flags[tcpsar_pkg::FLAG_FSNT] = i_item.fin_sent;
                    o_ctl.res_vld = ok;
                    o_res.kind    = tcpsar_pkg::KIND_INIT_PSH;
                    o_res.session = i_item.session;
                    o_res.acked   = i_item.seq_value;
                end else begin
                    // fin flags are sticky outside init
                    o_nxt.flags[tcpsar_pkg::FLAG_FRDY] =
                        cur.flags[tcpsar_pkg::FLAG_FRDY] | i_item.fin_ready;
                    o_nxt.flags[tcpsar_pkg::FLAG_FSNT] =
                        cur.flags[tcpsar_pkg::FLAG_FSNT] | i_item.fin_sent;
                end
            end
            tcpsar_pkg::ACT_RTX_WR: begin
                o_ctl.wr   = ok;
                o_nxt.ssth = i_item.threshold;
                o_nxt.cwnd = tcpsar_pkg::INIT_CWND;
            end
            tcpsar_pkg::ACT_APP_PSH: begin
                o_ctl.wr  = ok;
                o_nxt.app = i_item.seq_value[15:0];
            end
            tcpsar_pkg::ACT_RX_RD: begin
                o_ctl.res_vld     = 1'b1;
                o_res.kind        = tcpsar_pkg::KIND_RX_REPLY;
                o_res.acked       = cur.acked;
                o_res.not_acked   = cur.unacked;
                o_res.window      = cur.cwnd;
                o_res.threshold   = cur.ssth;
                o_res.dup_count   = cur.dup;
                o_res.fast_rexmit = cur.flags[tcpsar_pkg::FLAG_FRTX];
            end
            tcpsar_pkg::ACT_RX_WR: begin
                o_ctl.wr       = ok;
                o_nxt.acked    = i_item.seq_value;
                o_nxt.peer_win = i_item.rx_peer_win;
                o_nxt.cwnd     = i_item.rx_cwnd;
                o_nxt.dup      = i_item.dup_count;
                o_nxt.flags[tcpsar_pkg::FLAG_FRTX] = i_item.fast_rexmit;
                o_ctl.res_vld  = ok;
                o_res.kind     = tcpsar_pkg::KIND_ACK_PUSH;
                o_res.session  = i_item.session;
                o_res.acked    = i_item.seq_value;
            end
            default: begin
                o_ctl = '0;
            end
        endcase
    end

endmodule

// File: verif/tb.sv
module tb;

    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 12;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_action = '0;
    logic [4:0]  i_session = '0;
    logic [31:0] i_seq_value = '0;
    logic        i_init = 1'b0;
    logic        i_fin_ready_in = 1'b0;
    logic        i_fin_sent_in = 1'b0;
    logic [15:0] i_threshold_in = '0;
    logic [15:0] i_rx_peer_win_in = '0;
    logic [15:0] i_rx_cwnd_in = '0;
    logic [1:0]  i_dup_count_in = '0;
    logic        i_fast_rexmit_in = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_result_kind;
    logic [4:0]  o_session_out;
    logic [31:0] o_acked_out;
    logic [31:0] o_not_acked_out;
    logic [15:0] o_window_out;
    logic [15:0] o_app_ptr_out;
    logic        o_fin_ready_out;
    logic        o_fin_sent_out;
    logic [15:0] o_threshold_out;
    logic [1:0]  o_dup_count_out;
    logic        o_fast_rexmit_out;

    tcpsar_pkg::t_entry  sar_tbl [tcpsar_pkg::SESSIONS];
    tcpsar_pkg::t_result pending_results [$];
    int      mismatches = 0;
    int      cycle_count = 0;
    bit      idle_en = 1'b0;
    bit      stall_en = 1'b0;

    tcp_tx_sar_session_table_top u_dut (.*);

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        sar_tbl = '{default: '0};
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // updates the session table copy and returns 1 when the request yields a result
    function automatic bit predict_sar(input tcpsar_pkg::t_item req,
                                       output tcpsar_pkg::t_result res);
        tcpsar_pkg::t_entry e;
        res = '0;
        e = sar_tbl[req.session];
        case (req.action)
            tcpsar_pkg::ACT_TX_RD: begin
                res.kind      = tcpsar_pkg::KIND_TX_REPLY;
                res.acked     = e.acked;
                res.not_acked = e.unacked;
                res.window    = (e.cwnd < e.peer_win) ? e.cwnd : e.peer_win;
                res.app_ptr   = e.app;
                res.fin_ready = e.flags[tcpsar_pkg::FLAG_FRDY];
                res.fin_sent  = e.flags[tcpsar_pkg::FLAG_FSNT];
                return 1'b1;
            end
            tcpsar_pkg::ACT_TX_WR: begin
                e.unacked = req.seq_value;
                if (req.init) begin
                    e.app             = req.seq_value[15:0];
                    e.acked           = req.seq_value - 32'd1;
                    e.cwnd            = tcpsar_pkg::INIT_CWND;
                    e.ssth            = tcpsar_pkg::INIT_SSTH;
                    e.flags[tcpsar_pkg::FLAG_FRDY] = req.fin_ready;
                    e.flags[tcpsar_pkg::FLAG_FSNT] = req.fin_sent;
                    res.kind    = tcpsar_pkg::KIND_INIT_PSH;
                    res.session = req.session;
                    res.acked   = req.seq_value;
                end else begin
                    // fin flags are sticky outside init
                    e.flags[tcpsar_pkg::FLAG_FRDY] =
                        e.flags[tcpsar_pkg::FLAG_FRDY] | req.fin_ready;
                    e.flags[tcpsar_pkg::FLAG_FSNT] =
                        e.flags[tcpsar_pkg::FLAG_FSNT] | req.fin_sent;
                end
                sar_tbl[req.session] = e;
                return req.init;
            end
            tcpsar_pkg::ACT_RTX_WR: begin
                e.ssth = req.threshold;
                e.cwnd = tcpsar_pkg::INIT_CWND;
                sar_tbl[req.session] = e;
                return 1'b0;
            end
            tcpsar_pkg::ACT_APP_PSH: begin
                e.app = req.seq_value[15:0];
                sar_tbl[req.session] = e;
                return 1'b0;
            end
            tcpsar_pkg::ACT_RX_RD: begin
                res.kind        = tcpsar_pkg::KIND_RX_REPLY;
                res.acked       = e.acked;
                res.not_acked   = e.unacked;
                res.window      = e.cwnd;
                res.threshold   = e.ssth;
                res.dup_count   = e.dup;
                res.fast_rexmit = e.flags[tcpsar_pkg::FLAG_FRTX];
                return 1'b1;
            end
            tcpsar_pkg::ACT_RX_WR: begin
                e.acked            = req.seq_value;
                e.peer_win         = req.rx_peer_win;
                e.cwnd             = req.rx_cwnd;
                e.dup              = req.dup_count;
                e.flags[tcpsar_pkg::FLAG_FRTX] = req.fast_rexmit;
                sar_tbl[req.session] = e;
                res.kind    = tcpsar_pkg::KIND_ACK_PUSH;
                res.session = req.session;
                res.acked   = req.seq_value;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // result checking first, then prediction of the request taken at this edge
    always @(posedge i_clk) begin
        tcpsar_pkg::t_result want;
        tcpsar_pkg::t_result predicted;
        tcpsar_pkg::t_item   taken;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual kind %0d",
                             $time, o_result_kind);
                end else begin
                    want = pending_results.pop_front();
                    check_field("result_kind", 32'(want.kind), 32'(o_result_kind));
                    check_field("session_out", 32'(want.session), 32'(o_session_out));
                    check_field("acked_out", want.acked, o_acked_out);
                    check_field("not_acked_out", want.not_acked, o_not_acked_out);
                    check_field("window_out", 32'(want.window), 32'(o_window_out));
                    check_field("app_ptr_out", 32'(want.app_ptr), 32'(o_app_ptr_out));
                    check_field("fin_ready_out", 32'(want.fin_ready),
                                32'(o_fin_ready_out));
                    check_field("fin_sent_out", 32'(want.fin_sent), 32'(o_fin_sent_out));
                    check_field("threshold_out", 32'(want.threshold),
                                32'(o_threshold_out));
                    check_field("dup_count_out", 32'(want.dup_count),
                                32'(o_dup_count_out));
                    check_field("fast_rexmit_out", 32'(want.fast_rexmit),
                                32'(o_fast_rexmit_out));
                end
            end
            if (i_valid && !o_stall) begin
                taken.action      = i_action;
                taken.session     = i_session;
                taken.seq_value   = i_seq_value;
                taken.init        = i_init;
                taken.fin_ready   = i_fin_ready_in;
                taken.fin_sent    = i_fin_sent_in;
                taken.threshold   = i_threshold_in;
                taken.rx_peer_win = i_rx_peer_win_in;
                taken.rx_cwnd     = i_rx_cwnd_in;
                taken.dup_count   = i_dup_count_in;
                taken.fast_rexmit = i_fast_rexmit_in;
                if (predict_sar(taken, predicted)) pending_results.push_back(predicted);
            end
        end
    end

    // result-side backpressure in bursts
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_en && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send_request(input tcpsar_pkg::t_item req);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_action         <= req.action;
        i_session        <= req.session;
        i_seq_value      <= req.seq_value;
        i_init           <= req.init;
        i_fin_ready_in   <= req.fin_ready;
        i_fin_sent_in    <= req.fin_sent;
        i_threshold_in   <= req.threshold;
        i_rx_peer_win_in <= req.rx_peer_win;
        i_rx_cwnd_in     <= req.rx_cwnd;
        i_dup_count_in   <= req.dup_count;
        i_fast_rexmit_in <= req.fast_rexmit;
        i_valid          <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_plain(input logic [2:0] act, input logic [4:0] sess,
                              input logic [31:0] seq);
        tcpsar_pkg::t_item req;
        req = '0;
        req.action    = act;
        req.session   = sess;
        req.seq_value = seq;
        send_request(req);
    endtask

    task automatic send_tx_write(input logic [4:0] sess, input logic [31:0] seq,
                                 input logic init, input logic frdy, input logic fsnt);
        tcpsar_pkg::t_item req;
        req = '0;
        req.action    = tcpsar_pkg::ACT_TX_WR;
        req.session   = sess;
        req.seq_value = seq;
        req.init      = init;
        req.fin_ready = frdy;
        req.fin_sent  = fsnt;
        send_request(req);
    endtask

    task automatic send_rx_write(input logic [4:0] sess, input logic [31:0] seq,
                                 input logic [15:0] rwin, input logic [15:0] cwin,
                                 input logic [1:0] dup, input logic frtx);
        tcpsar_pkg::t_item req;
        req = '0;
        req.action      = tcpsar_pkg::ACT_RX_WR;
        req.session     = sess;
        req.seq_value   = seq;
        req.rx_peer_win = rwin;
        req.rx_cwnd     = cwin;
        req.dup_count   = dup;
        req.fast_rexmit = frtx;
        send_request(req);
    endtask

    task automatic send_retransmit(input logic [4:0] sess, input logic [15:0] thr);
        tcpsar_pkg::t_item req;
        req = '0;
        req.action    = tcpsar_pkg::ACT_RTX_WR;
        req.session   = sess;
        req.threshold = thr;
        send_request(req);
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_results.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic tcpsar_pkg::t_item random_request(input int sess_hi);
        tcpsar_pkg::t_item req;
        int    pick;
        req.session     = 5'($urandom_range(0, sess_hi));
        req.seq_value   = $urandom;
        req.init        = ($urandom_range(0, 2) == 0);
        req.fin_ready   = ($urandom_range(0, 3) == 0);
        req.fin_sent    = ($urandom_range(0, 3) == 0);
        req.threshold   = 16'($urandom_range(0, 16'hFFFF));
        req.rx_peer_win = 16'($urandom_range(0, 16'hFFFF));
        req.rx_cwnd     = 16'($urandom_range(0, 16'hFFFF));
        req.dup_count   = 2'($urandom_range(0, 3));
        req.fast_rexmit = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0: req.seq_value = 32'h0;
            1: req.seq_value = 32'hFFFF_FFFF;
            default: ;
        endcase
        if ($urandom_range(0, 7) == 0) req.rx_cwnd = req.rx_peer_win;
        pick = $urandom_range(0, 99);
        if (pick < 20)      req.action = tcpsar_pkg::ACT_TX_RD;
        else if (pick < 40) req.action = tcpsar_pkg::ACT_TX_WR;
        else if (pick < 50) req.action = tcpsar_pkg::ACT_RTX_WR;
        else if (pick < 60) req.action = tcpsar_pkg::ACT_APP_PSH;
        else if (pick < 75) req.action = tcpsar_pkg::ACT_RX_RD;
        else if (pick < 95) req.action = tcpsar_pkg::ACT_RX_WR;
        else                req.action = pick[0] ? ACT_SPARE_7 : ACT_SPARE_6;
        return req;
    endfunction

    task automatic test_reset_reads();
        send_plain(tcpsar_pkg::ACT_TX_RD, 5'd0, 32'h0);
        send_plain(tcpsar_pkg::ACT_RX_RD, 5'd31, 32'h0);
    endtask

    task automatic test_tx_write_init();
        // acked pointer wraps below zero
        send_tx_write(5'd1, 32'h0, 1'b1, 1'b0, 1'b0);
        send_plain(tcpsar_pkg::ACT_TX_RD, 5'd1, 32'h0);
        send_tx_write(5'd31, 32'h8000_0000, 1'b1, 1'b1, 1'b1);
    endtask

    task automatic test_fin_flags();
        send_tx_write(5'd1, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0);
        send_tx_write(5'd1, 32'h1234_5678, 1'b0, 1'b0, 1'b1);
        send_plain(tcpsar_pkg::ACT_TX_RD, 5'd1, 32'h0);
        // init overwrites the sticky flags
        send_tx_write(5'd1, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
    endtask

    task automatic test_rx_write_and_reads();
        send_rx_write(5'd1, 32'hFFFF_FFFF, 16'hFFFF, 16'h0, 2'd3, 1'b1);
        send_plain(tcpsar_pkg::ACT_RX_RD, 5'd1, 32'h0);
        send_plain(tcpsar_pkg::ACT_TX_RD, 5'd1, 32'h0);
        send_rx_write(5'd1, 32'h0, 16'h1000, 16'hFFFF, 2'd0, 1'b0);
        send_plain(tcpsar_pkg::ACT_TX_RD, 5'd1, 32'h0);
        send_plain(tcpsar_pkg::ACT_RX_RD, 5'd31, 32'h0);
    endtask

    task automatic test_retransmit();
        send_retransmit(5'd1, 16'h0);
        send_plain(tcpsar_pkg::ACT_RX_RD, 5'd1, 32'h0);
        send_retransmit(5'd1, 16'hFFFF);
    endtask

    task automatic test_app_push_and_unused();
        tcpsar_pkg::t_item req;
        send_plain(tcpsar_pkg::ACT_APP_PSH, 5'd1, 32'hABCD_0000);
        send_plain(tcpsar_pkg::ACT_APP_PSH, 5'd31, 32'hFFFF_FFFF);
        // spare action codes carry all-ones fields and must change nothing
        req = '1;
        req.action = ACT_SPARE_6;
        send_request(req);
        req.action = ACT_SPARE_7;
        send_request(req);
        send_plain(tcpsar_pkg::ACT_TX_RD, 5'd31, 32'h0);
        send_plain(tcpsar_pkg::ACT_TX_RD, 5'd1, 32'h0);
    endtask

    task automatic test_random_traffic(input int count, input bit with_idle);
        int sess_hi;
        sess_hi = 31;
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0) begin
                idle_en  = with_idle && ($urandom_range(0, 2) != 0);
                stall_en = with_idle && ($urandom_range(0, 2) != 0);
                // a few hot sessions give back-to-back hazards
                sess_hi  = $urandom_range(0, 1) ? 3 : 31;
            end
            send_request(random_request(sess_hi));
        end
    endtask

    task automatic test_pause_until_drained();
        wait_for_results();
        test_random_traffic(300, 1'b1);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_reads();
        test_tx_write_init();
        test_fin_flags();
        test_rx_write_and_reads();
        test_retransmit();
        test_app_push_and_unused();
        test_random_traffic(1200, 1'b1);
        test_pause_until_drained();
        test_random_traffic(326, 1'b0);
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
